>>> hw/rtl/escaped_frame_receiver_crc32_unit_macros.svh
// Assertion macros for the escaped frame receiver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ESCAPED_FRAME_RECEIVER_CRC32_UNIT_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_CRC32_UNIT_MACROS_SVH

// Same-cycle implication, quiet while reset is held.
`define EFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efr same-cycle check failed");

// Next-cycle implication, quiet while reset is held.
`define EFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efr next-cycle check failed");

`endif

>>> hw/rtl/efr_pkg.sv
// Package for the escaped frame receiver: status codes, register map, result
// and code structs and the byte-wide CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package efr_pkg;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_DATA     = 3'd1,
    ST_ACCEPTED = 3'd2,
    ST_LEN_BAD  = 3'd3,
    ST_CRC_BAD  = 3'd4,
    ST_OVERFLOW = 3'd5,
    ST_OPENED   = 3'd6
  } status_t;

  // Register map: byte address 4*index.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IDX_W  = 2;
  localparam logic [IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [IDX_W-1:0] REG_ESCAPE = 2'd1;
  localparam logic [IDX_W-1:0] REG_END    = 2'd2;

  localparam logic [7:0] START_RESET  = 8'd1;
  localparam logic [7:0] ESCAPE_RESET = 8'd27;
  localparam logic [7:0] END_RESET    = 8'd4;

  // Frame layout: three header bytes, payload, four CRC bytes.
  localparam int unsigned HEADER_LEN = 3;
  localparam int unsigned CRC_LEN    = 4;
  localparam int unsigned OVERHEAD   = 7;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] escape_code;
    logic [7:0] end_code;
  } codes_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_byte;
    logic [8:0] position;
    logic [7:0] dest_id;
    logic [7:0] source_id;
    logic [7:0] payload_len;
  } result_t;

  // Reflected CRC-32, one byte in.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/efr_in_if.sv
// Input channel of the escaped frame receiver: one raw line byte per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

>>> hw/rtl/efr_out_if.sv
// Result channel of the escaped frame receiver: one result per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface efr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] data_byte;
  logic [8:0] position;
  logic [7:0] dest_id;
  logic [7:0] source_id;
  logic [7:0] payload_len;

  modport source (output valid, output status, output data_byte, output position,
                  output dest_id, output source_id, output payload_len, input ready);
  modport sink   (input valid, input status, input data_byte, input position,
                  input dest_id, input source_id, input payload_len, output ready);
endinterface

>>> hw/rtl/efr_cfg_regs.sv
// APB register file for the start, escape and end codes.
// Depends on efr_pkg.
`timescale 1ns / 1ps

module efr_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efr_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output efr_pkg::codes_t              codes_o
);

  efr_pkg::codes_t           codes_r;
  efr_pkg::codes_t           codes_nxt;
  logic [efr_pkg::IDX_W-1:0] reg_idx;
  logic                      wr_en;

  assign reg_idx = paddr[efr_pkg::ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign codes_o = codes_r;

  always_comb begin
    codes_nxt = codes_r;
    if (wr_en) begin
      case (reg_idx)
        efr_pkg::REG_START:  codes_nxt.start_code  = pwdata[7:0];
        efr_pkg::REG_ESCAPE: codes_nxt.escape_code = pwdata[7:0];
        efr_pkg::REG_END:    codes_nxt.end_code    = pwdata[7:0];
        default:             codes_nxt = codes_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      efr_pkg::REG_START:  prdata = {24'd0, codes_r.start_code};
      efr_pkg::REG_ESCAPE: prdata = {24'd0, codes_r.escape_code};
      efr_pkg::REG_END:    prdata = {24'd0, codes_r.end_code};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.start_code  <= efr_pkg::START_RESET;
      codes_r.escape_code <= efr_pkg::ESCAPE_RESET;
      codes_r.end_code    <= efr_pkg::END_RESET;
    end else begin
      codes_r <= codes_nxt;
    end
  end

endmodule

>>> hw/rtl/efr_deframer.sv
// Frame state and one-byte decode step: unescaping, header capture, CRC over
// the bytes leaving the four-byte tail, and the end-of-frame checks. Uses efr_pkg.
`timescale 1ns / 1ps

module efr_deframer #(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_i,
  input  logic [7:0]      byte_i,
  input  efr_pkg::codes_t codes_i,
  output efr_pkg::result_t result_o,
  output logic            in_frame_o
);

  localparam int unsigned CW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned LW = (CW > 8) ? CW : 8;

  logic          in_frame_r, in_frame_nxt;
  logic          esc_r, esc_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [23:0]   hdr_r, hdr_nxt;
  logic [31:0]   tail_r, tail_nxt;
  logic [31:0]   crc_r, crc_nxt;

  assign in_frame_o = in_frame_r;

  always_comb begin
    logic [7:0]    d;
    logic          have_data;
    logic [CW-1:0] len_diff;
    logic          len_ok;
    d            = 8'd0;
    have_data    = 1'b0;
    len_diff     = count_r - CW'(efr_pkg::OVERHEAD);
    len_ok       = (count_r >= CW'(efr_pkg::OVERHEAD))
                   && (LW'(len_diff) == LW'(hdr_r[23:16]));
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    count_nxt    = count_r;
    hdr_nxt      = hdr_r;
    tail_nxt     = tail_r;
    crc_nxt      = crc_r;
    result_o     = '0;
    result_o.status = efr_pkg::ST_IGNORED;

    if (step_i) begin
      if (!in_frame_r) begin
        if (byte_i == codes_i.start_code) begin
          esc_nxt      = 1'b0;
          count_nxt    = '0;
          hdr_nxt      = '0;
          tail_nxt     = '0;
          crc_nxt      = efr_pkg::CRC_INIT;
          in_frame_nxt = 1'b1;
          result_o.status = efr_pkg::ST_OPENED;
        end
      end else if (count_r >= CW'(FRAME_BYTES)) begin
        // frame too long: drop it, whatever the byte is
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        count_nxt    = '0;
        hdr_nxt      = '0;
        tail_nxt     = '0;
        crc_nxt      = efr_pkg::CRC_INIT;
        result_o.status = efr_pkg::ST_OVERFLOW;
      end else if (esc_r) begin
        d         = byte_i ^ codes_i.escape_code;
        esc_nxt   = 1'b0;
        have_data = 1'b1;
      end else if (byte_i == codes_i.escape_code) begin
        esc_nxt = 1'b1;
      end else if (byte_i == codes_i.end_code) begin
        if (!len_ok) begin
          result_o.status = efr_pkg::ST_LEN_BAD;
        end else if ((crc_r ^ efr_pkg::CRC_INIT) != tail_r) begin
          result_o.status = efr_pkg::ST_CRC_BAD;
        end else begin
          result_o.status      = efr_pkg::ST_ACCEPTED;
          result_o.dest_id     = hdr_r[7:0];
          result_o.source_id   = hdr_r[15:8];
          result_o.payload_len = hdr_r[23:16];
        end
        in_frame_nxt = 1'b0;
        esc_nxt      = 1'b0;
        count_nxt    = '0;
        hdr_nxt      = '0;
        tail_nxt     = '0;
        crc_nxt      = efr_pkg::CRC_INIT;
      end else begin
        d         = byte_i;
        have_data = 1'b1;
      end

      if (have_data) begin
        if (count_r < CW'(efr_pkg::HEADER_LEN)) begin
          case (count_r[1:0])
            2'd0:    hdr_nxt[7:0]   = d;
            2'd1:    hdr_nxt[15:8]  = d;
            2'd2:    hdr_nxt[23:16] = d;
            default: hdr_nxt        = hdr_r;
          endcase
        end
        // the CRC trails the stream by four bytes so the tail is never fed
        if (count_r >= CW'(efr_pkg::CRC_LEN)) begin
          crc_nxt = efr_pkg::crc32_byte(crc_r, tail_r[31:24]);
        end
        tail_nxt  = {tail_r[23:0], d};
        count_nxt = count_r + 1'b1;
        result_o.status    = efr_pkg::ST_DATA;
        result_o.data_byte = d;
        result_o.position  = 9'(count_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      count_r    <= '0;
      hdr_r      <= '0;
      tail_r     <= '0;
      crc_r      <= efr_pkg::CRC_INIT;
    end else begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      count_r    <= count_nxt;
      hdr_r      <= hdr_nxt;
      tail_r     <= tail_nxt;
      crc_r      <= crc_nxt;
    end
  end

endmodule

>>> hw/rtl/escaped_frame_receiver_crc32_unit.sv
// Escaped frame receiver with CRC-32 check. Each transfer on in_ch carries one
// raw line byte; each yields exactly one result on out_ch, in order. Outside a
// frame, bytes are ignored until the start code opens one. Inside a frame the
// escape code makes the next byte data (XORed with the escape code), the end
// code closes the frame and reports accepted, length bad or CRC bad, and any
// other byte is streamed out with its position. A frame is laid out as
// destination, source, length, payload and a CRC-32 sent most significant byte
// first; a byte arriving once FRAME_BYTES decoded bytes are held aborts the
// frame with an overflow result. Rate: one byte per clock sustained while
// out_ch is ready; each byte goes through the input register, then the result
// register. The rate is set by the decode stage, which does the unescape, the
// byte-wide CRC-32 update and the length and CRC compare combinationally
// between the input register and the result register. The start, escape and
// end codes sit on the APB port at byte addresses 0, 4 and 8, and are to be
// changed only while the receiver is idle. Depends on efr_pkg, efr_in_if,
// efr_out_if, efr_cfg_regs, efr_deframer and the macros header.
`timescale 1ns / 1ps
`include "escaped_frame_receiver_crc32_unit_macros.svh"

module escaped_frame_receiver_crc32_unit #(
  parameter int unsigned FRAME_BYTES = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  efr_in_if.sink                     in_ch,
  efr_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [efr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  efr_pkg::codes_t  codes;
  efr_pkg::result_t step_res;
  logic             frame_open;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  // result register
  logic             out_valid_r, out_valid_nxt;
  efr_pkg::result_t out_res_r;

  logic in_xfer;
  logic advance;

  // Advance the input register into the result register whenever the result
  // register is empty or is being drained this cycle.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: hold unless a transfer refills them
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_ch.line_byte;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  efr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .codes_o (codes)
  );

  efr_deframer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_deframer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (advance),
    .byte_i     (s1_byte_r),
    .codes_i    (codes),
    .result_o   (step_res),
    .in_frame_o (frame_open)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_res_r.status;
  assign out_ch.data_byte   = out_res_r.data_byte;
  assign out_ch.position    = out_res_r.position;
  assign out_ch.dest_id     = out_res_r.dest_id;
  assign out_ch.source_id   = out_res_r.source_id;
  assign out_ch.payload_len = out_res_r.payload_len;

  // A data result never points past the frame buffer size.
  `EFR_ASSERT_IMP(a_pos_in_range,
    out_valid_r && (out_res_r.status == efr_pkg::ST_DATA),
    {1'b0, out_res_r.position} < 10'(FRAME_BYTES))

  // Header fields show only on an accepted frame.
  `EFR_ASSERT_IMP(a_hdr_only_on_accept,
    out_valid_r && (out_res_r.status != efr_pkg::ST_ACCEPTED),
    (out_res_r.dest_id == 8'd0) && (out_res_r.source_id == 8'd0)
      && (out_res_r.payload_len == 8'd0))

  // Every closing result leaves the deframer outside a frame.
  `EFR_ASSERT_NEXT(a_close_leaves_frame,
    advance && ((step_res.status == efr_pkg::ST_ACCEPTED)
      || (step_res.status == efr_pkg::ST_LEN_BAD)
      || (step_res.status == efr_pkg::ST_CRC_BAD)
      || (step_res.status == efr_pkg::ST_OVERFLOW)),
    !frame_open)

  // Opening a frame is only reported from outside one.
  `EFR_ASSERT_IMP(a_open_from_idle,
    advance && (step_res.status == efr_pkg::ST_OPENED),
    !frame_open)

endmodule

>>> dv/escaped_frame_receiver_crc32_unit_tb.sv
// Self-checking testbench for escaped_frame_receiver_crc32_unit: byte-stuffed frames,
// noise and oversize frames go in, every result is checked against a local deframer.
// Depends on efr_pkg, efr_in_if, efr_out_if and the receiver RTL.
`timescale 1ns / 1ps

module escaped_frame_receiver_crc32_unit_tb;

  localparam int unsigned FRAME_BYTES = 256;
  // Index with no register behind it; writes there must be dropped.
  localparam logic [efr_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [efr_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  efr_in_if in_ch ();
  efr_out_if out_ch ();

  escaped_frame_receiver_crc32_unit #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Deframer state as the receiver should hold it, plus the line codes.
  logic        rx_open;
  logic        rx_escaped;
  logic [9:0]  rx_count;
  logic [23:0] rx_header;
  logic [31:0] rx_tail;
  logic [31:0] rx_crc;
  logic [7:0]  code_start;
  logic [7:0]  code_escape;
  logic [7:0]  code_end;

  efr_pkg::result_t expected_results[$];
  int      fail_count;
  int      items_sent;
  bit      no_gap_run;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the receiver hangs or drops a result.
  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Reflected CRC-32, one byte, fed a bit at a time from the LSB.
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = r >> 1;
      if (fb) r = r ^ efr_pkg::CRC_POLY;
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    rx_open    = 1'b0;
    rx_escaped = 1'b0;
    rx_count   = '0;
    rx_header  = '0;
    rx_tail    = '0;
    rx_crc     = efr_pkg::CRC_INIT;
  endfunction

  // Advance the deframer by one line byte and return the result it must give.
  function automatic efr_pkg::result_t predict_line_byte(input logic [7:0] b);
    efr_pkg::result_t r;
    logic [7:0] d;
    logic [7:0] len;
    r = '0;
    r.status = efr_pkg::ST_IGNORED;
    if (!rx_open) begin
      if (b == code_start) begin
        clear_frame_state();
        rx_open  = 1'b1;
        r.status = efr_pkg::ST_OPENED;
      end
      return r;
    end
    // A full frame swallows whatever comes next, end and escape codes included.
    if (rx_count >= FRAME_BYTES) begin
      clear_frame_state();
      r.status = efr_pkg::ST_OVERFLOW;
      return r;
    end
    if (rx_escaped) begin
      d = b ^ code_escape;
      rx_escaped = 1'b0;
    end else if (b == code_escape) begin
      rx_escaped = 1'b1;
      return r;
    end else if (b == code_end) begin
      len = rx_header[23:16];
      if (rx_count < efr_pkg::OVERHEAD
          || {2'b00, len} != rx_count - 10'(efr_pkg::OVERHEAD)) begin
        r.status = efr_pkg::ST_LEN_BAD;
      end else if ((rx_crc ^ 32'hFFFF_FFFF) != rx_tail) begin
        r.status = efr_pkg::ST_CRC_BAD;
      end else begin
        r.status      = efr_pkg::ST_ACCEPTED;
        r.dest_id     = rx_header[7:0];
        r.source_id   = rx_header[15:8];
        r.payload_len = len;
      end
      clear_frame_state();
      return r;
    end else begin
      d = b;
    end
    // Decoded byte: latch the header, and run the CRC over bytes that leave
    // the four-byte tail, since the last four are the transmitted CRC.
    case (rx_count)
      10'd0: rx_header[7:0]   = d;
      10'd1: rx_header[15:8]  = d;
      10'd2: rx_header[23:16] = d;
      default: ;
    endcase
    if (rx_count >= efr_pkg::CRC_LEN) rx_crc = crc32_step(rx_crc, rx_tail[31:24]);
    rx_tail     = {rx_tail[23:0], d};
    r.status    = efr_pkg::ST_DATA;
    r.data_byte = d;
    r.position  = rx_count[8:0];
    rx_count    = rx_count + 10'd1;
    return r;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Result side: stall at random, with occasional long stretches held ready.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // Compare each result transfer with the oldest expectation.
  task automatic check_result();
    efr_pkg::result_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: status %0d data %02h pos %0d",
                 out_ch.status, out_ch.data_byte, out_ch.position);
      return;
    end
    want = expected_results.pop_front();
    if (out_ch.status !== want.status || out_ch.data_byte !== want.data_byte ||
        out_ch.position !== want.position || out_ch.dest_id !== want.dest_id ||
        out_ch.source_id !== want.source_id || out_ch.payload_len !== want.payload_len) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("mismatch: expected st %0d data %02h pos %0d dst %02h src %02h len %02h",
                 want.status, want.data_byte, want.position, want.dest_id,
                 want.source_id, want.payload_len);
        $display("          actual   st %0d data %02h pos %0d dst %02h src %02h len %02h",
                 out_ch.status, out_ch.data_byte, out_ch.position, out_ch.dest_id,
                 out_ch.source_id, out_ch.payload_len);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_result();
  end

  // Offer one line byte, hold it until the transfer, then maybe leave a gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.line_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    expected_results.push_back(predict_line_byte(b));
    items_sent++;
    gap = no_gap_run ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and hold off until every result is back and the pipe is empty.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Stuff one decoded byte; now and then escape a byte that needs no escaping.
  task automatic push_encoded(input logic [7:0] d);
    if (d == code_escape || d == code_end || $urandom_range(0, 19) == 0) begin
      send_byte(code_escape);
      send_byte(d ^ code_escape);
    end else begin
      send_byte(d);
    end
  endtask

  // Append the CRC (MSB first) to header and payload and send the whole frame.
  task automatic send_frame(input byte_q_t body, input bit spoil_crc);
    logic [31:0] fcs;
    int          k;
    fcs = efr_pkg::CRC_INIT;
    foreach (body[i]) fcs = crc32_step(fcs, body[i]);
    fcs = ~fcs;
    body.push_back(fcs[31:24]);
    body.push_back(fcs[23:16]);
    body.push_back(fcs[15:8]);
    body.push_back(fcs[7:0]);
    // Flip one bit anywhere but the length byte, so only the CRC check trips.
    if (spoil_crc) begin
      k = $urandom_range(0, body.size() - 1);
      if (k == 2) k = 3;
      body[k] = body[k] ^ (8'd1 << $urandom_range(0, 7));
    end
    send_byte(code_start);
    foreach (body[i]) push_encoded(body[i]);
    send_byte(code_end);
  endtask

  function automatic byte_q_t make_frame_body(input int plen, input logic [7:0] len_field);
    byte_q_t q;
    q = {};
    q.push_back(8'($urandom));
    q.push_back(8'($urandom));
    q.push_back(len_field);
    repeat (plen) q.push_back(8'($urandom));
    return q;
  endfunction

  // Short payloads mostly; full-size frames come from the frame limit test.
  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 12);
    return $urandom_range(13, 40);
  endfunction

  // Close whatever frame noise left open; an escape may eat the first end code.
  task automatic close_open_frame();
    while (rx_open) send_byte(code_end);
  endtask

  task automatic apb_access(input logic wr, input logic [efr_pkg::IDX_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_code(input logic [efr_pkg::IDX_W-1:0] idx, input logic [7:0] value);
    logic [31:0] unused;
    apb_access(1'b1, idx, {24'd0, value}, unused);
    case (idx)
      efr_pkg::REG_START:  code_start  = value;
      efr_pkg::REG_ESCAPE: code_escape = value;
      efr_pkg::REG_END:    code_end    = value;
      default: ;
    endcase
  endtask

  // Read back the three code registers.
  task automatic check_codes();
    logic [31:0] rd;
    logic [7:0]  want;
    logic [efr_pkg::IDX_W-1:0] idx;
    for (int i = 0; i < 3; i++) begin
      idx  = efr_pkg::IDX_W'(i);
      want = (idx == efr_pkg::REG_START)  ? code_start :
             (idx == efr_pkg::REG_ESCAPE) ? code_escape : code_end;
      apb_access(1'b0, idx, 32'd0, rd);
      if (rd[7:0] !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("register %0d read back: expected %02h actual %02h", i, want, rd[7:0]);
      end
    end
  endtask

  // Only while idle: write all codes, poke the unused index, read back.
  task automatic apply_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] n);
    write_code(efr_pkg::REG_START, s);
    write_code(efr_pkg::REG_ESCAPE, e);
    write_code(efr_pkg::REG_END, n);
    write_code(REG_UNUSED, 8'($urandom));
    check_codes();
  endtask

  // Reset codes: ignored bytes outside a frame, short frames, and a small
  // frame whose header holds the end and escape codes and whose payload holds
  // the start code and both byte extremes.
  task automatic test_directed_cases();
    byte_q_t body;
    check_codes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(code_escape);
    send_byte(code_end);
    send_byte(code_start);
    send_byte(code_end);
    send_byte(code_start);
    send_byte(8'hAA);
    send_byte(8'h55);
    send_byte(code_end);
    body = {code_end, code_escape, 8'd3, code_start, 8'hFF, 8'h00};
    send_frame(body, 1'b0);
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise.
  task automatic test_random_traffic(input int n_items);
    int first;
    int pick;
    int plen;
    first = items_sent;
    while (items_sent - first < n_items) begin
      no_gap_run = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      plen = pick_payload_len();
      if (pick < 60) begin
        send_frame(make_frame_body(plen, plen[7:0]), 1'b0);
      end else if (pick < 72) begin
        send_frame(make_frame_body(plen, plen[7:0]), 1'b1);
      end else if (pick < 82) begin
        send_frame(make_frame_body(plen, 8'(plen + int'($urandom_range(1, 255)))), 1'b0);
      end else if (pick < 90) begin
        send_byte(code_start);
        repeat ($urandom_range(0, 6)) push_encoded(8'($urandom));
        send_byte(code_end);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        close_open_frame();
      end
      // Pause now and then until every result is back.
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
    no_gap_run = 1'b0;
  endtask

  // Largest frame that passes, one byte too many at the end code, and a
  // full frame aborted by an escape code.
  task automatic test_frame_limits();
    close_open_frame();
    send_frame(make_frame_body(248, 8'd248), 1'b0);
    send_frame(make_frame_body(249, 8'd249), 1'b0);
    send_byte(code_start);
    repeat (FRAME_BYTES) push_encoded(8'($urandom));
    send_byte(code_escape);
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    logic [7:0] n;
    fail_count = 0;
    items_sent = 0;
    no_gap_run = 1'b0;
    code_start  = efr_pkg::START_RESET;
    code_escape = efr_pkg::ESCAPE_RESET;
    code_end    = efr_pkg::END_RESET;
    clear_frame_state();
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.line_byte <= 8'd0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= 32'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();

    wait_drained();
    apply_codes(8'h00, 8'hFF, 8'h80);
    test_random_traffic(50);

    wait_drained();
    apply_codes(8'hFF, 8'h00, 8'hFE);
    test_random_traffic(50);

    // Random codes; the escape and end codes must differ for frames to close.
    wait_drained();
    s = 8'($urandom);
    do begin
      e = 8'($urandom);
      n = 8'($urandom);
    end while (e == n);
    apply_codes(s, e, n);
    test_random_traffic(50);
    test_frame_limits();

    wait_drained();
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> escaped_frame_receiver_crc32_unit.f
+incdir+hw/rtl
hw/rtl/efr_pkg.sv
hw/rtl/efr_in_if.sv
hw/rtl/efr_out_if.sv
hw/rtl/efr_cfg_regs.sv
hw/rtl/efr_deframer.sv
hw/rtl/escaped_frame_receiver_crc32_unit.sv
dv/escaped_frame_receiver_crc32_unit_tb.sv
